// ===== hw/rtl/tcpu_pkg.sv =====
// shared types and constants of the three-register execute block
// payload structs, opcode values, status codes and serial unit operation codes
// no dependencies
`default_nettype none

package tcpu_pkg;

	// instruction opcodes
	localparam logic [7:0] OP_MOV   = 8'h01;
	localparam logic [7:0] OP_ADD   = 8'h10;
	localparam logic [7:0] OP_SUB   = 8'h11;
	localparam logic [7:0] OP_MUL   = 8'h09;
	localparam logic [7:0] OP_DIV   = 8'h08;
	localparam logic [7:0] OP_AND   = 8'h12;
	localparam logic [7:0] OP_OR    = 8'h13;
	localparam logic [7:0] OP_XOR   = 8'h14;
	localparam logic [7:0] OP_NOT   = 8'h15;
	localparam logic [7:0] OP_NAND  = 8'h16;
	localparam logic [7:0] OP_NOR   = 8'h17;
	localparam logic [7:0] OP_PRINT = 8'h40;
	localparam logic [7:0] OP_HALT  = 8'hFF;

	// operand selectors that name a register
	localparam logic [7:0] SEL_A = 8'd0;
	localparam logic [7:0] SEL_B = 8'd1;
	localparam logic [7:0] SEL_C = 8'd2;

	// response status codes
	localparam logic [2:0] ST_DONE    = 3'd0;
	localparam logic [2:0] ST_HALT    = 3'd1;
	localparam logic [2:0] ST_UNKNOWN = 3'd2;
	localparam logic [2:0] ST_DIVZERO = 3'd3;
	localparam logic [2:0] ST_IGNORED = 3'd4;

	// serial unit operations
	localparam logic [3:0] ALU_MOV  = 4'd0;
	localparam logic [3:0] ALU_ADD  = 4'd1;
	localparam logic [3:0] ALU_SUB  = 4'd2;
	localparam logic [3:0] ALU_MUL  = 4'd3;
	localparam logic [3:0] ALU_DIV  = 4'd4;
	localparam logic [3:0] ALU_AND  = 4'd5;
	localparam logic [3:0] ALU_OR   = 4'd6;
	localparam logic [3:0] ALU_XOR  = 4'd7;
	localparam logic [3:0] ALU_NOT  = 4'd8;
	localparam logic [3:0] ALU_NAND = 4'd9;
	localparam logic [3:0] ALU_NOR  = 4'd10;

	localparam int unsigned DATA_W = 8;
	localparam int unsigned STEP_W = $clog2(DATA_W);

	typedef struct packed {
		logic [7:0] opcode;
		logic [7:0] first_operand;
		logic [7:0] second_operand;
	} tcpu_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        bad_destination;
		logic        print_valid;
		logic [7:0]  print_value;
		logic [7:0]  reg_a_value;
		logic [7:0]  reg_b_value;
		logic [7:0]  reg_c_value;
		logic [15:0] next_pc;
		logic [31:0] cycle_count;
	} tcpu_rsp_t;

	// start request to the serial unit
	typedef struct packed {
		logic       start;
		logic [3:0] op;
		logic [7:0] lhs;
		logic [7:0] rhs;
	} tcpu_alu_req_t;

	// completion from the serial unit
	typedef struct packed {
		logic       done;
		logic [7:0] result;
	} tcpu_alu_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/three_register_cpu_execute_top.sv =====
// execute stage of a three-register 8-bit machine
// holds registers A, B, C, pc, cycle total and the stop flag; math in tcpu_alu
// depends on tcpu_pkg and tcpu_alu
//
// usage
//   request channel: req_valid / req_ready with req carrying opcode and two
//   operand bytes; one request is taken at an edge where both are high
//   response channel: rsp_valid / rsp_ready with rsp carrying status, flags,
//   the three registers, next pc and cycle count; one response per request
// request paths
//   arithmetic and logic requests pass from acceptance to rsp_valid through
//   8 bit-serial steps in tcpu_alu, its done flag, one write-back and one response load
//   print, halt, unknown opcode, divide by zero and requests after stop
//   skip the serial unit and the write-back and go straight to the response load
//   one request in flight at a time; the next request is taken once the
//   previous one has reached the response register
// reset
//   arst_n low clears registers, pc, cycle total, stop flag and rsp_valid
// stall
//   a response held by rsp_ready low stays stable in the output register;
//   one further request may be taken and executed behind it and waits
//   in its final state until the output register frees up
`default_nettype none

module three_register_cpu_execute_top (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_ready,
	input  tcpu_pkg::tcpu_req_t req,
	output logic                rsp_valid,
	input  wire                 rsp_ready,
	output tcpu_pkg::tcpu_rsp_t rsp
);
	import tcpu_pkg::*;

	// control states
	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_EXEC   = 2'd1;
	localparam logic [1:0] S_WRITE  = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	logic [1:0]  state_q;
	logic [7:0]  reg_a_q;
	logic [7:0]  reg_b_q;
	logic [7:0]  reg_c_q;
	logic [15:0] pc_q;
	logic [31:0] cyc_q;
	logic        stopped_q;

	// per-request bookkeeping
	logic [7:0]  dest_q;
	logic [3:0]  cost_q;
	logic [1:0]  len_q;
	logic [2:0]  status_q;
	logic        bad_q;
	logic        pvalid_q;
	logic [7:0]  pval_q;
	logic [7:0]  res_q;

	tcpu_rsp_t   rsp_q;
	logic        rsp_valid_q;

	tcpu_alu_req_t alu_req;
	tcpu_alu_rsp_t alu_rsp;

	logic        req_fire;
	logic        rsp_load;
	logic [7:0]  lhs;
	logic [7:0]  rhs;

	// decoded request
	logic [3:0]  dec_alu_op;
	logic        dec_use_alu;
	logic [3:0]  dec_cost;
	logic [1:0]  dec_len;
	logic [2:0]  dec_status;
	logic        dec_print;
	logic        dec_stop;

	function automatic logic [7:0] operand_value(input logic [7:0] sel, input logic [7:0] ra,
			input logic [7:0] rb, input logic [7:0] rc);
		logic [7:0] v;
		v = sel;
		if (sel == SEL_A) v = ra;
		if (sel == SEL_B) v = rb;
		if (sel == SEL_C) v = rc;
		return v;
	endfunction

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign rsp_load  = (state_q == S_FINISH) && (!rsp_valid_q || rsp_ready);

	assign lhs = operand_value(req.first_operand, reg_a_q, reg_b_q, reg_c_q);
	assign rhs = operand_value(req.second_operand, reg_a_q, reg_b_q, reg_c_q);

	always_comb begin
		dec_alu_op  = ALU_MOV;
		dec_use_alu = 1'b1;
		dec_cost    = 4'd0;
		dec_len     = 2'd3;
		dec_status  = ST_DONE;
		dec_print   = 1'b0;
		dec_stop    = 1'b0;
		unique case (req.opcode)
			OP_MOV:  begin dec_alu_op = ALU_MOV;  dec_cost = 4'd3; end
			OP_ADD:  begin dec_alu_op = ALU_ADD;  dec_cost = 4'd3; end
			OP_SUB:  begin dec_alu_op = ALU_SUB;  dec_cost = 4'd3; end
			OP_MUL:  begin dec_alu_op = ALU_MUL;  dec_cost = 4'd5; end
			OP_DIV: begin
				dec_alu_op = ALU_DIV;
				if (rhs == 8'd0) begin
					// divide by zero: pc moves, cycle total unchanged, block stops
					dec_use_alu = 1'b0;
					dec_status  = ST_DIVZERO;
					dec_stop    = 1'b1;
				end else begin
					dec_cost = 4'd10;
				end
			end
			OP_AND:  begin dec_alu_op = ALU_AND;  dec_cost = 4'd1; end
			OP_OR:   begin dec_alu_op = ALU_OR;   dec_cost = 4'd1; end
			OP_XOR:  begin dec_alu_op = ALU_XOR;  dec_cost = 4'd1; end
			OP_NOT:  begin dec_alu_op = ALU_NOT;  dec_cost = 4'd1; dec_len = 2'd2; end
			OP_NAND: begin dec_alu_op = ALU_NAND; dec_cost = 4'd2; end
			OP_NOR:  begin dec_alu_op = ALU_NOR;  dec_cost = 4'd2; end
			OP_PRINT: begin
				dec_use_alu = 1'b0;
				dec_print   = 1'b1;
				dec_cost    = 4'd2;
				dec_len     = 2'd2;
			end
			OP_HALT: begin
				dec_use_alu = 1'b0;
				dec_cost    = 4'd1;
				dec_len     = 2'd1;
				dec_status  = ST_HALT;
				dec_stop    = 1'b1;
			end
			default: begin
				dec_use_alu = 1'b0;
				dec_len     = 2'd1;
				dec_status  = ST_UNKNOWN;
				dec_stop    = 1'b1;
			end
		endcase
	end

	// start the serial unit for arithmetic and logic requests while running
	assign alu_req.start = req_fire && !stopped_q && dec_use_alu;
	assign alu_req.op    = dec_alu_op;
	assign alu_req.lhs   = lhs;
	assign alu_req.rhs   = rhs;

	tcpu_alu u_alu (
		.clk     (clk),
		.arst_n  (arst_n),
		.alu_req (alu_req),
		.alu_rsp (alu_rsp)
	);

	// control state and architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			reg_a_q     <= 8'd0;
			reg_b_q     <= 8'd0;
			reg_c_q     <= 8'd0;
			pc_q        <= 16'd0;
			cyc_q       <= 32'd0;
			stopped_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						if (!stopped_q && dec_use_alu) begin
							state_q <= S_EXEC;
						end else begin
							state_q <= S_FINISH;
						end
						if (!stopped_q && dec_stop) begin
							stopped_q <= 1'b1;
						end
					end
				end
				S_EXEC: begin
					if (alu_rsp.done) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					// register destination written; an immediate destination leaves the registers unchanged
					if (dest_q == SEL_A) reg_a_q <= res_q;
					if (dest_q == SEL_B) reg_b_q <= res_q;
					if (dest_q == SEL_C) reg_c_q <= res_q;
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (rsp_load) begin
						pc_q    <= pc_q + {14'd0, len_q};
						cyc_q   <= cyc_q + {28'd0, cost_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			priority if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request bookkeeping and response payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			dest_q <= req.first_operand;
			bad_q  <= 1'b0;
			if (stopped_q) begin
				// already stopped: report unchanged state
				cost_q   <= 4'd0;
				len_q    <= 2'd0;
				status_q <= ST_IGNORED;
				pvalid_q <= 1'b0;
				pval_q   <= 8'd0;
			end else begin
				cost_q   <= dec_cost;
				len_q    <= dec_len;
				status_q <= dec_status;
				pvalid_q <= dec_print;
				pval_q   <= dec_print ? lhs : 8'd0;
			end
		end
		if (state_q == S_EXEC && alu_rsp.done) begin
			res_q <= alu_rsp.result;
			bad_q <= (dest_q != SEL_A) && (dest_q != SEL_B) && (dest_q != SEL_C);
		end
		if (rsp_load) begin
			rsp_q.status          <= status_q;
			rsp_q.bad_destination <= bad_q;
			rsp_q.print_valid     <= pvalid_q;
			rsp_q.print_value     <= pval_q;
			rsp_q.reg_a_value     <= reg_a_q;
			rsp_q.reg_b_value     <= reg_b_q;
			rsp_q.reg_c_value     <= reg_c_q;
			rsp_q.next_pc         <= pc_q + {14'd0, len_q};
			rsp_q.cycle_count     <= cyc_q + {28'd0, cost_q};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tcpu_alu.sv =====
// bit-serial arithmetic and logic unit, one bit per cycle
// add, sub and logic lsb first, mul by shift and add, div by restoring steps
// depends on tcpu_pkg
`default_nettype none

module tcpu_alu (
	input  wire                    clk,
	input  wire                    arst_n,
	input  tcpu_pkg::tcpu_alu_req_t alu_req,
	output tcpu_pkg::tcpu_alu_rsp_t alu_rsp
);
	import tcpu_pkg::*;

	logic [7:0]        a_q;
	logic [7:0]        b_q;
	logic [7:0]        r_q;
	logic [7:0]        rem_q;
	logic              carry_q;
	logic [3:0]        op_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic       x_bit;
	logic       y_bit;
	logic       res_bit;
	logic       carry_next;
	logic [9:0] div_diff;
	logic       div_ge;
	logic [7:0] mul_sum;

	assign x_bit = a_q[0];
	assign y_bit = (op_q == ALU_SUB) ? ~b_q[0] : b_q[0];

	always_comb begin
		carry_next = carry_q;
		unique case (op_q)
			ALU_ADD, ALU_SUB: begin
				res_bit    = x_bit ^ y_bit ^ carry_q;
				carry_next = (x_bit & y_bit) | (carry_q & (x_bit ^ y_bit));
			end
			ALU_MOV:  res_bit = y_bit;
			ALU_AND:  res_bit = x_bit & y_bit;
			ALU_OR:   res_bit = x_bit | y_bit;
			ALU_XOR:  res_bit = x_bit ^ y_bit;
			ALU_NOT:  res_bit = ~x_bit;
			ALU_NAND: res_bit = ~(x_bit & y_bit);
			ALU_NOR:  res_bit = ~(x_bit | y_bit);
			default:  res_bit = 1'b0;
		endcase
	end

	// restoring divide step: remainder stays below the divisor
	assign div_diff = {1'b0, rem_q, a_q[7]} - {2'b00, b_q};
	assign div_ge   = ~div_diff[9];
	assign mul_sum  = r_q + (b_q[0] ? a_q : 8'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !alu_req.start && (cnt_q == STEP_W'(DATA_W - 1));
			if (alu_req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == STEP_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (alu_req.start) begin
			a_q     <= alu_req.lhs;
			b_q     <= alu_req.rhs;
			r_q     <= 8'd0;
			rem_q   <= 8'd0;
			carry_q <= (alu_req.op == ALU_SUB);
			op_q    <= alu_req.op;
		end else if (busy_q) begin
			unique case (op_q)
				ALU_MUL: begin
					r_q <= mul_sum;
					a_q <= {a_q[6:0], 1'b0};
					b_q <= {1'b0, b_q[7:1]};
				end
				ALU_DIV: begin
					rem_q <= div_ge ? div_diff[7:0] : {rem_q[6:0], a_q[7]};
					a_q   <= {a_q[6:0], div_ge};
				end
				default: begin
					r_q     <= {res_bit, r_q[7:1]};
					a_q     <= {1'b0, a_q[7:1]};
					b_q     <= {1'b0, b_q[7:1]};
					carry_q <= carry_next;
				end
			endcase
		end
	end

	assign alu_rsp.done   = done_q;
	assign alu_rsp.result = (op_q == ALU_DIV) ? a_q : r_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tcpu_checker.sv =====
// port-level checker for the three-register execute block, bound to the top level
// watches the request and response channels over time
// depends on tcpu_pkg and three_register_cpu_execute_top
`default_nettype none

module tcpu_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 req_valid,
	input wire                 req_ready,
	input wire                 rsp_valid,
	input wire                 rsp_ready,
	input tcpu_pkg::tcpu_rsp_t rsp
);
	import tcpu_pkg::*;

	// a pending response holds until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// one request at a time: no acceptance right after an acceptance
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in flight");

	// ignored and stopping requests neither print nor flag a destination
	a_stop_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_IGNORED || rsp.status == ST_HALT ||
			rsp.status == ST_UNKNOWN || rsp.status == ST_DIVZERO)
		|-> !rsp.print_valid && !rsp.bad_destination)
		else $error("stopped request reported print or bad destination");

	// print value is zero unless a print happened
	a_print_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.print_valid |-> rsp.print_value == 8'd0)
		else $error("print value without print");

endmodule

bind three_register_cpu_execute_top tcpu_checker u_tcpu_checker (.*);

`default_nettype wire

// ===== tb/sv/three_register_cpu_execute_top_tb.sv =====
// self-checking bench for the three-register execute stage
// runs directed and random instruction streams against an in-bench machine model
// depends on tcpu_pkg and three_register_cpu_execute_top
`timescale 1ns / 1ps

module three_register_cpu_execute_top_tb;
	import tcpu_pkg::*;

	// cycles with no handshake on either channel before the run is abandoned
	localparam int unsigned QUIET_LIMIT = 2000;
	// drain time after the last response, longer than the serial path latency
	localparam int unsigned TAIL_CYCLES = 20;
	localparam int unsigned SHOWN_MISMATCHES = 10;

	// how the machine is finally stopped; only one stop fits in a run
	typedef enum int unsigned {
		STOP_HALT,
		STOP_UNKNOWN,
		STOP_DIVZERO
	} stop_kind_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	tcpu_req_t req;
	logic      rsp_valid;
	logic      rsp_ready;
	tcpu_rsp_t rsp;

	// machine state as the model sees it
	logic [7:0]  mach_a;
	logic [7:0]  mach_b;
	logic [7:0]  mach_c;
	logic [15:0] mach_pc;
	logic [31:0] mach_cycles;
	logic        mach_stopped;

	// predicted responses, oldest first
	tcpu_rsp_t   retire_q[$];
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;
	// when low, both sides run back to back
	bit          idle_en;

	three_register_cpu_execute_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// value an operand byte stands for: a register or the byte itself
	function automatic logic [7:0] operand_of(logic [7:0] sel);
		unique case (sel)
			SEL_A: return mach_a;
			SEL_B: return mach_b;
			SEL_C: return mach_c;
			default: return sel;
		endcase
	endfunction

	// opcodes that keep the machine running
	function automatic logic [7:0] run_op(int unsigned k);
		unique case (k)
			0: return OP_MOV;
			1: return OP_ADD;
			2: return OP_SUB;
			3: return OP_MUL;
			4: return OP_DIV;
			5: return OP_AND;
			6: return OP_OR;
			7: return OP_XOR;
			8: return OP_NOT;
			9: return OP_NAND;
			10: return OP_NOR;
			default: return OP_PRINT;
		endcase
	endfunction

	// executes one instruction on the model state and returns the response
	function automatic tcpu_rsp_t execute_insn(tcpu_req_t r);
		tcpu_rsp_t   o;
		logic [7:0]  lhs;
		logic [7:0]  rhs;
		logic [7:0]  res;
		logic [31:0] cost;
		logic [15:0] len;
		logic        has_res;
		o = '0;
		o.status = ST_DONE;
		if (mach_stopped) begin
			o.status = ST_IGNORED;
		end else begin
			lhs = operand_of(r.first_operand);
			rhs = operand_of(r.second_operand);
			res = 8'h00;
			cost = 32'd0;
			len = 16'd3;
			has_res = 1'b1;
			unique case (r.opcode)
				OP_MOV: begin res = rhs; cost = 32'd3; end
				OP_ADD: begin res = lhs + rhs; cost = 32'd3; end
				OP_SUB: begin res = lhs - rhs; cost = 32'd3; end
				OP_MUL: begin res = lhs * rhs; cost = 32'd5; end
				OP_DIV: begin
					cost = 32'd10;
					if (rhs == 8'h00) begin
						o.status = ST_DIVZERO;
						has_res = 1'b0;
					end else begin
						res = lhs / rhs;
					end
				end
				OP_AND: begin res = lhs & rhs; cost = 32'd1; end
				OP_OR: begin res = lhs | rhs; cost = 32'd1; end
				OP_XOR: begin res = lhs ^ rhs; cost = 32'd1; end
				OP_NOT: begin res = ~lhs; cost = 32'd1; len = 16'd2; end
				OP_NAND: begin res = ~(lhs & rhs); cost = 32'd2; end
				OP_NOR: begin res = ~(lhs | rhs); cost = 32'd2; end
				OP_PRINT: begin
					o.print_valid = 1'b1;
					o.print_value = lhs;
					cost = 32'd2;
					len = 16'd2;
					has_res = 1'b0;
				end
				OP_HALT: begin
					o.status = ST_HALT;
					cost = 32'd1;
					has_res = 1'b0;
				end
				default: begin
					o.status = ST_UNKNOWN;
					has_res = 1'b0;
				end
			endcase
			if (o.status == ST_HALT || o.status == ST_UNKNOWN) begin
				mach_pc = mach_pc + 16'd1;
				mach_cycles = mach_cycles + cost;
				mach_stopped = 1'b1;
			end else if (o.status == ST_DIVZERO) begin
				mach_pc = mach_pc + 16'd3;
				mach_stopped = 1'b1;
			end else begin
				if (has_res) begin
					unique case (r.first_operand)
						SEL_A: mach_a = res;
						SEL_B: mach_b = res;
						SEL_C: mach_c = res;
						default: o.bad_destination = 1'b1;
					endcase
				end
				mach_pc = mach_pc + len;
				mach_cycles = mach_cycles + cost;
			end
		end
		o.reg_a_value = mach_a;
		o.reg_b_value = mach_b;
		o.reg_c_value = mach_c;
		o.next_pc = mach_pc;
		o.cycle_count = mach_cycles;
		return o;
	endfunction

	// sends one request, holds it until taken, then records its prediction
	task automatic issue(logic [7:0] op, logic [7:0] dst, logic [7:0] src);
		tcpu_req_t   item;
		int unsigned gap;
		item.opcode = op;
		item.first_operand = dst;
		item.second_operand = src;
		gap = idle_en ? $urandom_range(0, 19) : 0;
		// valid stays up across back-to-back requests, so it is only lowered for a gap
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		retire_q.push_back(execute_insn(item));
	endtask

	// holds off new requests until every outstanding response is back
	task automatic drain_retire();
		req_valid <= 1'b0;
		while (retire_q.size() != 0) @(posedge clk);
	endtask

	// every opcode but halt, with register and immediate sources, edge values included
	task automatic test_each_operation();
		issue(OP_MOV, SEL_A, 8'hFF);
		issue(OP_MOV, SEL_B, 8'h80);
		issue(OP_MOV, SEL_C, 8'h03);
		issue(OP_ADD, SEL_A, SEL_B);
		issue(OP_SUB, SEL_C, SEL_A);
		issue(OP_MUL, SEL_A, SEL_C);
		issue(OP_DIV, SEL_B, SEL_C);
		issue(OP_DIV, SEL_A, 8'h03);
		issue(OP_AND, SEL_A, 8'hF0);
		issue(OP_OR, SEL_B, 8'h0F);
		issue(OP_XOR, SEL_C, 8'hFF);
		// not and print take one operand, the second byte is junk
		issue(OP_NOT, SEL_A, 8'hFF);
		issue(OP_NAND, SEL_B, SEL_C);
		issue(OP_NOR, SEL_C, SEL_A);
		issue(OP_PRINT, SEL_B, 8'hA5);
		issue(OP_PRINT, 8'hAB, 8'h00);
		issue(OP_MOV, SEL_A, SEL_A);
	endtask

	// immediate destinations flag the response and leave registers alone
	task automatic test_bad_destination();
		issue(OP_ADD, 8'h03, SEL_A);
		issue(OP_MOV, 8'hFF, 8'h07);
		issue(OP_NOT, 8'h10, 8'h5A);
		issue(OP_DIV, 8'h40, 8'h03);
		issue(OP_NOR, 8'h80, SEL_C);
	endtask

	// long running program, random operands, divisor kept nonzero
	task automatic test_random_program(int unsigned count);
		logic [7:0]  op;
		logic [7:0]  dst;
		logic [7:0]  src;
		int unsigned n;
		for (n = 0; n < count; n++) begin
			// a back-to-back stretch in the middle, then a full drain
			idle_en = !(n >= 250 && n < 350);
			if (n == 350) drain_retire();
			op = run_op($urandom_range(0, 11));
			if ($urandom_range(0, 9) == 0) begin
				dst = 8'($urandom);
				src = 8'($urandom);
			end else begin
				dst = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 2))
					: 8'($urandom_range(3, 255));
				src = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 2))
					: 8'($urandom_range(0, 255));
			end
			// the state at this point is the state the request will see
			if (op == OP_DIV && operand_of(src) == 8'h00) src = 8'($urandom_range(3, 255));
			issue(op, dst, src);
		end
	endtask

	// one stop of a random kind, then fully random requests that must be ignored
	task automatic test_stop_and_ignore();
		stop_kind_t  kind;
		logic [7:0]  op;
		logic [7:0]  dst;
		logic [7:0]  src;
		logic [7:0]  sel;
		int unsigned k;
		int unsigned n;
		bit          hit;
		idle_en = 1'b1;
		kind = stop_kind_t'($urandom_range(0, 2));
		dst = 8'($urandom);
		src = 8'($urandom);
		unique case (kind)
			STOP_HALT: issue(OP_HALT, dst, src);
			STOP_UNKNOWN: begin
				hit = 1'b1;
				while (hit) begin
					op = 8'($urandom);
					hit = (op == OP_HALT);
					for (k = 0; k < 12; k++) if (run_op(k) == op) hit = 1'b1;
				end
				issue(op, dst, src);
			end
			default: begin
				// clear a register, then divide by it
				sel = 8'($urandom_range(0, 2));
				issue(OP_SUB, sel, sel);
				issue(OP_DIV, 8'($urandom_range(0, 2)), sel);
			end
		endcase
		for (n = 0; n < 30; n++) begin
			op = 8'($urandom);
			dst = 8'($urandom);
			src = 8'($urandom);
			issue(op, dst, src);
		end
	endtask

	// response side: random stalls, every accepted response checked in order
	initial begin : rsp_side
		tcpu_rsp_t   want;
		int unsigned stall;
		bit          differs;
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = idle_en ? $urandom_range(0, 19) : 0;
			if (stall != 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			// rsp here is the value that was on the port at the accepting edge
			if (retire_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= SHOWN_MISMATCHES)
					$display("%0t response with no request outstanding: %h", $realtime, rsp);
			end else begin
				want = retire_q.pop_front();
				differs = (rsp.status !== want.status)
					|| (rsp.bad_destination !== want.bad_destination)
					|| (rsp.print_valid !== want.print_valid)
					|| (rsp.print_value !== want.print_value)
					|| (rsp.reg_a_value !== want.reg_a_value)
					|| (rsp.reg_b_value !== want.reg_b_value)
					|| (rsp.reg_c_value !== want.reg_c_value)
					|| (rsp.next_pc !== want.next_pc)
					|| (rsp.cycle_count !== want.cycle_count);
				if (differs) begin
					mismatch_count++;
					if (mismatch_count <= SHOWN_MISMATCHES) begin
						$display("%0t mismatch, expected: st %0d bad %b pr %b/%h abc %h %h %h pc %h cyc %h",
							$realtime, want.status, want.bad_destination, want.print_valid,
							want.print_value, want.reg_a_value, want.reg_b_value,
							want.reg_c_value, want.next_pc, want.cycle_count);
						$display("%0t mismatch, actual:   st %0d bad %b pr %b/%h abc %h %h %h pc %h cyc %h",
							$realtime, rsp.status, rsp.bad_destination, rsp.print_valid,
							rsp.print_value, rsp.reg_a_value, rsp.reg_b_value,
							rsp.reg_c_value, rsp.next_pc, rsp.cycle_count);
					end
				end
			end
		end
	end

	// watchdog: a hung handshake on either side ends the run
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t no handshake for %0d cycles", $realtime, quiet_cycles);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// main sequence: reset once, then each test in turn
	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		idle_en = 1'b1;
		mach_a = 8'h00;
		mach_b = 8'h00;
		mach_c = 8'h00;
		mach_pc = 16'h0000;
		mach_cycles = 32'h0;
		mach_stopped = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_each_operation();
		test_bad_destination();
		test_random_program(560);
		// stopping is final, so it goes last
		test_stop_and_ignore();

		// last request was just taken, lower valid and let responses drain
		req_valid <= 1'b0;
		while (retire_q.size() != 0) @(posedge clk);
		// extra cycles catch a stray response after the last one
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && retire_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/tcpu_pkg.sv
hw/rtl/tcpu_alu.sv
hw/rtl/three_register_cpu_execute_top.sv
hw/rtl/tcpu_checker.sv
tb/sv/three_register_cpu_execute_top_tb.sv
